// ===== rtl/tpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types, phase and error codes for the text packet header parser.
// ----------------------------------------------------------------------------
package tpp_pkg;

  localparam int LEN_BITS = 16;
  localparam int ACC_W    = LEN_BITS + 1;
  localparam logic [15:0] MAX_LEN_RST = 16'hFFFF;

  // parse phases
  localparam logic [3:0] PH_PROTO_START = 4'd0;
  localparam logic [3:0] PH_PROTO       = 4'd1;
  localparam logic [3:0] PH_METHOD      = 4'd2;
  localparam logic [3:0] PH_METHOD_LF   = 4'd3;
  localparam logic [3:0] PH_NAME        = 4'd4;
  localparam logic [3:0] PH_VALUE_LEAD  = 4'd5;
  localparam logic [3:0] PH_VALUE       = 4'd6;
  localparam logic [3:0] PH_HDR_LF      = 4'd7;
  localparam logic [3:0] PH_END_LF      = 4'd8;
  localparam logic [3:0] PH_BODY        = 4'd9;

  // field kinds
  localparam logic [2:0] KIND_DELIM  = 3'd0;
  localparam logic [2:0] KIND_PROTO  = 3'd1;
  localparam logic [2:0] KIND_METHOD = 3'd2;
  localparam logic [2:0] KIND_NAME   = 3'd3;
  localparam logic [2:0] KIND_VALUE  = 3'd4;
  localparam logic [2:0] KIND_BODY   = 3'd5;

  // error codes
  localparam logic [3:0] ERR_OK           = 4'd0;
  localparam logic [3:0] ERR_PROTO_START  = 4'd1;
  localparam logic [3:0] ERR_PROTO_CHAR   = 4'd2;
  localparam logic [3:0] ERR_METHOD_START = 4'd3;
  localparam logic [3:0] ERR_METHOD_CHAR  = 4'd4;
  localparam logic [3:0] ERR_MISSING_LF   = 4'd5;
  localparam logic [3:0] ERR_NAME_START   = 4'd6;
  localparam logic [3:0] ERR_NAME_CHAR    = 4'd7;
  localparam logic [3:0] ERR_VALUE_CHAR   = 4'd8;
  localparam logic [3:0] ERR_DUP_LENGTH   = 4'd9;
  localparam logic [3:0] ERR_BAD_LENGTH   = 4'd10;
  localparam logic [3:0] ERR_TOO_LONG     = 4'd11;
  localparam logic [3:0] ERR_HALTED       = 4'd12;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic [2:0]  field_kind;
    logic        field_first;
    logic        header_done;
    logic        is_length_header;
    logic        packet_end;
    logic [15:0] body_length;
    logic [3:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic [3:0]          phase;
    logic                at_start;
    logic [3:0]          match_pos;
    logic                match_ok;
    logic [ACC_W-1:0]    acc;
    logic                digits_ok;
    logic [LEN_BITS-1:0] body_len;
    logic [LEN_BITS-1:0] body_cnt;
    logic                halted;
  } parse_state_t;

  // state at the start of a packet; halted flag left to the caller
  function automatic parse_state_t packet_init(input logic halted);
    parse_state_t s;
    s.phase     = PH_PROTO_START;
    s.at_start  = 1'b0;
    s.match_pos = 4'd0;
    s.match_ok  = 1'b1;
    s.acc       = '0;
    s.digits_ok = 1'b1;
    s.body_len  = '0;
    s.body_cnt  = '0;
    s.halted    = halted;
    return s;
  endfunction

endpackage

// ===== rtl/tpp_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_in_reg
// Input register stage; takes a new item whenever it is empty or draining.
// ----------------------------------------------------------------------------
module tpp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpp_pkg::in_item_t in_item,
  input  logic              adv,
  output logic              q_vld,
  output tpp_pkg::in_item_t q_item
);

  logic              vld_r;
  logic              vld_nxt;
  tpp_pkg::in_item_t item_r;
  tpp_pkg::in_item_t item_nxt;
  logic              take;

  assign in_ready = !vld_r || adv;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (take) begin
      vld_nxt  = 1'b1;
      item_nxt = in_item;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign q_vld  = vld_r;
  assign q_item = item_r;

endmodule

// ===== rtl/tpp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_step
// Per-byte grammar check: next parse state and the tagged result for one item.
// ----------------------------------------------------------------------------
module tpp_step (
  input  tpp_pkg::parse_state_t st,
  input  tpp_pkg::in_item_t     item,
  input  logic [15:0]           max_len,
  output tpp_pkg::parse_state_t st_nxt,
  output tpp_pkg::out_item_t    res
);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [3:0] KEY_LEN  = 4'd14;
  localparam logic [tpp_pkg::ACC_W-1:0] ACC_LIMIT =
    {1'b1, {tpp_pkg::LEN_BITS{1'b0}}};
  localparam int MUL_W = tpp_pkg::ACC_W + 4;

  // "content-length", lower case
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] k;
    unique case (pos)
      4'd0:    k = 8'h63;
      4'd1:    k = 8'h6F;
      4'd2:    k = 8'h6E;
      4'd3:    k = 8'h74;
      4'd4:    k = 8'h65;
      4'd5:    k = 8'h6E;
      4'd6:    k = 8'h74;
      4'd7:    k = 8'h2D;
      4'd8:    k = 8'h6C;
      4'd9:    k = 8'h65;
      4'd10:   k = 8'h6E;
      4'd11:   k = 8'h67;
      4'd12:   k = 8'h74;
      4'd13:   k = 8'h68;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  logic [7:0] c;
  logic       is_upper, is_lower, is_digit, is_alpha, is_ident, is_print;
  logic [7:0] c_low;
  logic [3:0] m_pos;       // match position used for this byte
  logic       m_ok;
  logic       m_ok_nxt;
  logic [3:0] m_pos_nxt;
  logic [MUL_W-1:0] acc_mul;
  logic [tpp_pkg::ACC_W-1:0] acc_dig;
  logic [tpp_pkg::LEN_BITS-1:0] cnt_inc;
  logic [3:0] err;
  logic       pend;
  tpp_pkg::parse_state_t nx;

  assign c        = item.data_byte;
  assign is_upper = (c >= 8'h41) && (c <= 8'h5A);
  assign is_lower = (c >= 8'h61) && (c <= 8'h7A);
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = is_upper || is_lower;
  assign is_ident = is_upper || is_digit || (c == CH_UNDER);
  assign is_print = (c >= CH_SP) && (c < CH_TILDE);
  assign c_low    = is_upper ? (c | 8'h20) : c;

  // a name start restarts the key compare at position 0
  assign m_pos = st.at_start ? 4'd0 : st.match_pos;
  assign m_ok  = st.at_start ? 1'b1 : st.match_ok;
  assign m_ok_nxt  = m_ok && (m_pos < KEY_LEN) && (c_low == key_char(m_pos));
  assign m_pos_nxt = (m_pos < 4'd15) ? m_pos + 4'd1 : m_pos;

  // acc * 10 + digit, saturated at 2^LEN_BITS
  assign acc_mul = ({4'b0, st.acc} << 3) + ({4'b0, st.acc} << 1)
                 + {{(MUL_W-4){1'b0}}, c[3:0]};
  assign acc_dig = (acc_mul > {4'b0, ACC_LIMIT}) ? ACC_LIMIT
                                                  : acc_mul[tpp_pkg::ACC_W-1:0];

  assign cnt_inc = st.body_cnt + {{(tpp_pkg::LEN_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    nx   = st;
    res  = '0;
    err  = tpp_pkg::ERR_OK;
    pend = 1'b0;
    res.echo_byte   = c;
    res.body_length = st.body_len;
    if (item.action) begin
      nx  = tpp_pkg::packet_init(1'b0);
      res = '0;
    end else if (st.halted) begin
      res.error_code = tpp_pkg::ERR_HALTED;
    end else begin
      unique case (st.phase)
        tpp_pkg::PH_PROTO: begin
          if (is_ident) begin
            res.field_kind = tpp_pkg::KIND_PROTO;
          end else if (c == CH_SP) begin
            nx.phase    = tpp_pkg::PH_METHOD;
            nx.at_start = 1'b1;
          end else begin
            res.field_kind = tpp_pkg::KIND_PROTO;
            err            = tpp_pkg::ERR_PROTO_CHAR;
          end
        end
        tpp_pkg::PH_METHOD: begin
          if (st.at_start) begin
            res.field_kind = tpp_pkg::KIND_METHOD;
            if (is_upper) begin
              res.field_first = 1'b1;
              nx.at_start     = 1'b0;
            end else begin
              err = tpp_pkg::ERR_METHOD_START;
            end
          end else if (is_ident) begin
            res.field_kind = tpp_pkg::KIND_METHOD;
          end else if (c == CH_CR) begin
            nx.phase = tpp_pkg::PH_METHOD_LF;
          end else begin
            res.field_kind = tpp_pkg::KIND_METHOD;
            err            = tpp_pkg::ERR_METHOD_CHAR;
          end
        end
        tpp_pkg::PH_METHOD_LF, tpp_pkg::PH_HDR_LF: begin
          if (c == CH_LF) begin
            nx.phase    = tpp_pkg::PH_NAME;
            nx.at_start = 1'b1;
          end else begin
            err = tpp_pkg::ERR_MISSING_LF;
          end
        end
        tpp_pkg::PH_NAME: begin
          if (st.at_start) begin
            if (is_alpha) begin
              res.field_kind  = tpp_pkg::KIND_NAME;
              res.field_first = 1'b1;
              nx.at_start     = 1'b0;
              nx.match_pos    = m_pos_nxt;
              nx.match_ok     = m_ok_nxt;
            end else if (c == CH_CR) begin
              nx.at_start = 1'b0;
              nx.phase    = tpp_pkg::PH_END_LF;
            end else begin
              res.field_kind = tpp_pkg::KIND_NAME;
              err            = tpp_pkg::ERR_NAME_START;
            end
          end else if (is_alpha || is_digit || (c == CH_UNDER) || (c == CH_DASH)) begin
            res.field_kind = tpp_pkg::KIND_NAME;
            nx.match_pos   = m_pos_nxt;
            nx.match_ok    = m_ok_nxt;
          end else if (c == CH_COLON) begin
            nx.match_ok  = st.match_ok && (st.match_pos == KEY_LEN);
            nx.acc       = '0;
            nx.digits_ok = 1'b1;
            nx.phase     = tpp_pkg::PH_VALUE_LEAD;
          end else begin
            res.field_kind = tpp_pkg::KIND_NAME;
            err            = tpp_pkg::ERR_NAME_CHAR;
          end
        end
        tpp_pkg::PH_VALUE_LEAD, tpp_pkg::PH_VALUE: begin
          if ((st.phase == tpp_pkg::PH_VALUE_LEAD) && (c == CH_SP)) begin
            // leading space, skipped
          end else if (is_print) begin
            res.field_kind  = tpp_pkg::KIND_VALUE;
            res.field_first = (st.phase == tpp_pkg::PH_VALUE_LEAD);
            nx.phase        = tpp_pkg::PH_VALUE;
            if (st.match_ok) begin
              if (is_digit) begin
                nx.acc = acc_dig;
              end else begin
                nx.digits_ok = 1'b0;
              end
            end
          end else if (c == CH_CR) begin
            if (st.match_ok) begin
              priority if (st.body_len != '0) begin
                err = tpp_pkg::ERR_DUP_LENGTH;
              end else if (!st.digits_ok || (st.acc == '0)) begin
                err = tpp_pkg::ERR_BAD_LENGTH;
              end else if (st.acc > {1'b0, max_len}) begin
                err = tpp_pkg::ERR_TOO_LONG;
              end else begin
                nx.body_len          = st.acc[tpp_pkg::LEN_BITS-1:0];
                res.is_length_header = 1'b1;
              end
            end
            if (err == tpp_pkg::ERR_OK) begin
              res.header_done = 1'b1;
              nx.phase        = tpp_pkg::PH_HDR_LF;
            end
          end else begin
            res.field_kind = tpp_pkg::KIND_VALUE;
            err            = tpp_pkg::ERR_VALUE_CHAR;
          end
        end
        tpp_pkg::PH_END_LF: begin
          if (c != CH_LF) begin
            err = tpp_pkg::ERR_MISSING_LF;
          end else if (st.body_len == '0) begin
            pend = 1'b1;
          end else begin
            nx.body_cnt = '0;
            nx.phase    = tpp_pkg::PH_BODY;
          end
        end
        tpp_pkg::PH_BODY: begin
          res.field_kind  = tpp_pkg::KIND_BODY;
          res.field_first = (st.body_cnt == '0);
          nx.body_cnt     = cnt_inc;
          pend            = (cnt_inc >= st.body_len);
        end
        default: begin
          // protocol start; unused phase codes behave the same
          res.field_kind = tpp_pkg::KIND_PROTO;
          if (is_upper) begin
            res.field_first = 1'b1;
            nx.phase        = tpp_pkg::PH_PROTO;
          end else begin
            err = tpp_pkg::ERR_PROTO_START;
          end
        end
      endcase

      res.error_code = err;
      if (err != tpp_pkg::ERR_OK) begin
        // no partial update survives an error
        nx                   = st;
        nx.halted            = 1'b1;
        res.header_done      = 1'b0;
        res.is_length_header = 1'b0;
        res.body_length      = st.body_len;
      end else if (pend) begin
        res.packet_end  = 1'b1;
        res.body_length = st.body_len;
        nx              = tpp_pkg::packet_init(1'b0);
      end else begin
        res.body_length = nx.body_len;
      end
    end
  end

  assign st_nxt = nx;

endmodule

// ===== rtl/text_packet_header_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_packet_header_parser_unit
// Byte-wise packet grammar checker: tags each byte with field and error code.
// ----------------------------------------------------------------------------
//  channel | ports                              | moves
//  --------+------------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_item        | one byte or restart per item
//  result  | out_valid, out_ready, out_item     | one tagged byte per item
//  config  | cfg_we, cfg_wdata                  | max_body_length, no read-back
//
//  One item per cycle while the result port is not stalled; an accepted item
//  passes the input register, one parse step and the result register.
//  The parse state updates in the single cycle the item leaves the input register.
//  Reset clears packet state and halt flag and sets max_body_length to 65535.
//  A stalled result holds the parse step; the input register keeps taking items
//  as long as its item moves on in the same cycle.
// ----------------------------------------------------------------------------
module text_packet_header_parser_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tpp_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tpp_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  logic                  in_vld;
  tpp_pkg::in_item_t     in_q;
  logic                  adv;
  tpp_pkg::parse_state_t st_r;
  tpp_pkg::parse_state_t st_nxt;
  tpp_pkg::parse_state_t step_st;
  tpp_pkg::out_item_t    res;
  logic [15:0]           max_len_r;
  logic [15:0]           max_len_nxt;
  logic                  out_vld_r;
  logic                  out_vld_nxt;
  tpp_pkg::out_item_t    out_item_r;
  tpp_pkg::out_item_t    out_item_nxt;

  assign adv = in_vld && (!out_vld_r || out_ready);

  tpp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .adv      (adv),
    .q_vld    (in_vld),
    .q_item   (in_q)
  );

  tpp_step u_step (
    .st      (st_r),
    .item    (in_q),
    .max_len (max_len_r),
    .st_nxt  (step_st),
    .res     (res)
  );

  always_comb begin
    st_nxt       = adv ? step_st : st_r;
    max_len_nxt  = cfg_we ? cfg_wdata : max_len_r;
    out_item_nxt = adv ? res : out_item_r;
    out_vld_nxt  = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= tpp_pkg::packet_init(1'b0);
      max_len_r <= tpp_pkg::MAX_LEN_RST;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      max_len_r <= max_len_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_q.action |=> !st_r.halted && (st_r.phase == tpp_pkg::PH_PROTO_START))
    else $error("restart item did not clear the parse state");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !in_q.action && (res.error_code != tpp_pkg::ERR_OK) |=> st_r.halted)
    else $error("error item did not halt the parser");

  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.halted && !(adv && in_q.action) |=>
      st_r.halted && $stable(st_r.phase) && $stable(st_r.body_len))
    else $error("parse state moved while halted");

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == tpp_pkg::PH_BODY |-> st_r.body_cnt < st_r.body_len)
    else $error("body count reached length without packet end");

  a_packet_end: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.packet_end |=>
      (st_r.body_len == '0) && (st_r.phase == tpp_pkg::PH_PROTO_START))
    else $error("packet end did not start a new packet");
`endif

endmodule

// ===== dv/text_packet_header_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_packet_header_parser_unit_tb
// Self-checking bench for the packet header parser. A short directed table
// hits several error codes, halting, restart and a bodyless packet. It is
// followed by randomized packets (content-length headers, bodies, corrupted,
// truncated and noise streams) under several body length limits. Results are
// checked field by field against a typed row or a bit-accurate parse model.
// ----------------------------------------------------------------------------
module text_packet_header_parser_unit_tb;

  localparam logic [7:0] CR = 8'h0D;
  localparam logic [7:0] LF = 8'h0A;
  localparam logic [7:0] SP = 8'h20;
  localparam int KEY_LEN = 14;
  localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "content-length";
  localparam int PHASE_ITEMS = 60;

  typedef struct {
    tpp_pkg::in_item_t  item;
    bit                 typed;
    tpp_pkg::out_item_t want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  tpp_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  tpp_pkg::out_item_t out_item;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;

  // sideband travelling with each offered item: typed expectation, if any
  bit                 row_typed;
  tpp_pkg::out_item_t row_want;

  tpp_pkg::out_item_t tag_q[$];
  tpp_pkg::in_item_t  tx_q[$];
  stim_row_t          dir_tab[$];
  int                 err_count;
  int                 items_sent;
  int                 burst_left;
  bit                 steady_send;
  bit                 hold_req;

  // parse model state
  logic [3:0]  ps_phase;
  logic        ps_field_start;
  logic [3:0]  ps_key_pos;
  logic        ps_key_ok;
  logic [16:0] ps_len_acc;
  logic        ps_digits_ok;
  logic [15:0] ps_pkt_len;
  logic [15:0] ps_body_cnt;
  logic        ps_halted;
  logic [15:0] ps_max_len;

  text_packet_header_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic bit is_upper(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return is_upper(c) || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_ident(logic [7:0] c);
    return is_upper(c) || is_digit(c) || c == "_";
  endfunction

  function automatic void start_packet();
    ps_phase       = tpp_pkg::PH_PROTO_START;
    ps_field_start = 1'b0;
    ps_key_pos     = '0;
    ps_key_ok      = 1'b1;
    ps_len_acc     = '0;
    ps_digits_ok   = 1'b1;
    ps_pkt_len     = '0;
    ps_body_cnt    = '0;
  endfunction

  function automatic void match_key(logic [7:0] c);
    logic [7:0] low;
    low = is_upper(c) ? c + 8'd32 : c;
    if (ps_key_pos >= KEY_LEN) begin
      ps_key_ok = 1'b0;
    end else if (low != KEY_TEXT[8*(KEY_LEN-1-int'(ps_key_pos)) +: 8]) begin
      ps_key_ok = 1'b0;
    end
    if (ps_key_pos < 4'd15) ps_key_pos++;
  endfunction

  function automatic tpp_pkg::out_item_t parse_byte(tpp_pkg::in_item_t it);
    tpp_pkg::out_item_t r;
    logic [7:0]         c;
    logic [15:0]        blen;
    int unsigned        acc;
    r = '0;
    if (it.action) begin
      ps_halted = 1'b0;
      start_packet();
      return r;
    end
    c = it.data_byte;
    r.echo_byte = c;
    blen = ps_pkt_len;
    if (ps_halted) begin
      r.error_code = tpp_pkg::ERR_HALTED;
    end else begin
      case (ps_phase)
        tpp_pkg::PH_PROTO: begin
          if (is_ident(c)) begin
            r.field_kind = tpp_pkg::KIND_PROTO;
          end else if (c == SP) begin
            ps_phase = tpp_pkg::PH_METHOD;
            ps_field_start = 1'b1;
          end else begin
            r.field_kind = tpp_pkg::KIND_PROTO;
            r.error_code = tpp_pkg::ERR_PROTO_CHAR;
          end
        end
        tpp_pkg::PH_METHOD: begin
          if (ps_field_start) begin
            r.field_kind = tpp_pkg::KIND_METHOD;
            if (is_upper(c)) begin
              r.field_first = 1'b1;
              ps_field_start = 1'b0;
            end else begin
              r.error_code = tpp_pkg::ERR_METHOD_START;
            end
          end else if (is_ident(c)) begin
            r.field_kind = tpp_pkg::KIND_METHOD;
          end else if (c == CR) begin
            ps_phase = tpp_pkg::PH_METHOD_LF;
          end else begin
            r.field_kind = tpp_pkg::KIND_METHOD;
            r.error_code = tpp_pkg::ERR_METHOD_CHAR;
          end
        end
        tpp_pkg::PH_METHOD_LF, tpp_pkg::PH_HDR_LF: begin
          if (c == LF) begin
            ps_phase = tpp_pkg::PH_NAME;
            ps_field_start = 1'b1;
          end else begin
            r.error_code = tpp_pkg::ERR_MISSING_LF;
          end
        end
        tpp_pkg::PH_NAME: begin
          if (ps_field_start) begin
            if (is_alpha(c)) begin
              r.field_kind = tpp_pkg::KIND_NAME;
              r.field_first = 1'b1;
              ps_field_start = 1'b0;
              ps_key_pos = '0;
              ps_key_ok = 1'b1;
              match_key(c);
            end else if (c == CR) begin
              ps_field_start = 1'b0;
              ps_phase = tpp_pkg::PH_END_LF;
            end else begin
              r.field_kind = tpp_pkg::KIND_NAME;
              r.error_code = tpp_pkg::ERR_NAME_START;
            end
          end else if (is_alpha(c) || is_digit(c) || c == "_" || c == "-") begin
            r.field_kind = tpp_pkg::KIND_NAME;
            match_key(c);
          end else if (c == ":") begin
            ps_key_ok = ps_key_ok && ps_key_pos == KEY_LEN;
            ps_len_acc = '0;
            ps_digits_ok = 1'b1;
            ps_phase = tpp_pkg::PH_VALUE_LEAD;
          end else begin
            r.field_kind = tpp_pkg::KIND_NAME;
            r.error_code = tpp_pkg::ERR_NAME_CHAR;
          end
        end
        tpp_pkg::PH_VALUE_LEAD, tpp_pkg::PH_VALUE: begin
          // leading spaces are dropped silently
          if (!(ps_phase == tpp_pkg::PH_VALUE_LEAD && c == SP)) begin
            if (c >= 8'd32 && c < 8'd126) begin
              r.field_kind = tpp_pkg::KIND_VALUE;
              r.field_first = ps_phase == tpp_pkg::PH_VALUE_LEAD;
              ps_phase = tpp_pkg::PH_VALUE;
              if (ps_key_ok) begin
                if (is_digit(c)) begin
                  acc = 32'(ps_len_acc) * 10 + (int'(c) - 48);
                  if (acc > 65536) acc = 65536;
                  ps_len_acc = 17'(acc);
                end else begin
                  ps_digits_ok = 1'b0;
                end
              end
            end else if (c == CR) begin
              if (ps_key_ok) begin
                if (ps_pkt_len != 0) r.error_code = tpp_pkg::ERR_DUP_LENGTH;
                else if (!ps_digits_ok || ps_len_acc == 0)
                  r.error_code = tpp_pkg::ERR_BAD_LENGTH;
                else if (ps_len_acc > 17'(ps_max_len))
                  r.error_code = tpp_pkg::ERR_TOO_LONG;
                else begin
                  ps_pkt_len = ps_len_acc[15:0];
                  r.is_length_header = 1'b1;
                end
              end
              if (r.error_code == tpp_pkg::ERR_OK) begin
                r.header_done = 1'b1;
                ps_phase = tpp_pkg::PH_HDR_LF;
              end
            end else begin
              r.field_kind = tpp_pkg::KIND_VALUE;
              r.error_code = tpp_pkg::ERR_VALUE_CHAR;
            end
          end
        end
        tpp_pkg::PH_END_LF: begin
          if (c != LF) begin
            r.error_code = tpp_pkg::ERR_MISSING_LF;
          end else if (ps_pkt_len == 0) begin
            r.packet_end = 1'b1;
          end else begin
            ps_body_cnt = '0;
            ps_phase = tpp_pkg::PH_BODY;
          end
        end
        tpp_pkg::PH_BODY: begin
          r.field_kind = tpp_pkg::KIND_BODY;
          r.field_first = ps_body_cnt == 0;
          ps_body_cnt++;
          if (ps_body_cnt >= ps_pkt_len) r.packet_end = 1'b1;
        end
        default: begin
          r.field_kind = tpp_pkg::KIND_PROTO;
          if (is_upper(c)) begin
            r.field_first = 1'b1;
            ps_phase = tpp_pkg::PH_PROTO;
          end else begin
            r.error_code = tpp_pkg::ERR_PROTO_START;
          end
        end
      endcase
      if (r.error_code != tpp_pkg::ERR_OK) ps_halted = 1'b1;
      if (r.packet_end) start_packet();
      else blen = ps_pkt_len;
    end
    r.body_length = blen;
    return r;
  endfunction

  // ------------------------------------------------------------- checking
  task automatic report_mismatch(string msg);
    if (err_count < 40) $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    tpp_pkg::out_item_t want;
    if (rst_n) begin
      // results first, so an item taken this edge cannot match its own slot
      if (out_valid && out_ready) begin
        if (tag_q.size() == 0) begin
          report_mismatch($sformatf("result byte %0d with nothing expected",
                                    out_item.echo_byte));
        end else begin
          want = tag_q.pop_front();
          check_field("echo_byte", out_item.echo_byte, want.echo_byte);
          check_field("field_kind", out_item.field_kind, want.field_kind);
          check_field("field_first", out_item.field_first, want.field_first);
          check_field("header_done", out_item.header_done, want.header_done);
          check_field("is_length_header", out_item.is_length_header,
                      want.is_length_header);
          check_field("packet_end", out_item.packet_end, want.packet_end);
          check_field("body_length", out_item.body_length, want.body_length);
          check_field("error_code", out_item.error_code, want.error_code);
        end
      end
      if (in_valid && in_ready) begin
        want = parse_byte(in_item);
        tag_q.push_back(row_typed ? row_want : want);
      end
    end
  end

  // ------------------------------------------------------------- receiver
  initial begin
    int mode;
    int left;
    int held;
    out_ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (held = 1; held < 80; held++) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 80);
        end
        left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 99) < 70;
          2: out_ready <= $urandom_range(0, 99) < 25;
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // --------------------------------------------------------------- sender
  function automatic tpp_pkg::in_item_t mk_in(logic act, logic [7:0] b);
    tpp_pkg::in_item_t r;
    r.action = act;
    r.data_byte = b;
    return r;
  endfunction

  function automatic tpp_pkg::out_item_t mk_result(logic [7:0] b, logic [2:0] kind,
                                                   logic first, logic pend,
                                                   logic [3:0] err);
    tpp_pkg::out_item_t r;
    r = '0;
    r.echo_byte = b;
    r.field_kind = kind;
    r.field_first = first;
    r.packet_end = pend;
    r.error_code = err;
    return r;
  endfunction

  function automatic stim_row_t row(logic act, logic [7:0] b, bit typed,
                                    tpp_pkg::out_item_t want);
    stim_row_t r;
    r.item = mk_in(act, b);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(tpp_pkg::in_item_t it, bit typed, tpp_pkg::out_item_t want);
    int gap;
    if (!steady_send && burst_left == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid  <= 1'b1;
    in_item   <= it;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained(int extra);
    in_valid <= 1'b0;
    while (tag_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_max_len(logic [15:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ps_max_len = v;
  endtask

  // ------------------------------------------------------- packet builder
  task automatic put_byte(logic [7:0] b);
    tx_q.push_back(mk_in(1'b0, b));
  endtask

  task automatic put_text(string s);
    for (int j = 0; j < s.len(); j++) put_byte(s[j]);
  endtask

  function automatic logic [7:0] rand_upper();
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_ident();
    int r;
    r = $urandom_range(0, 37);
    if (r < 26) return 8'("A" + r);
    if (r < 36) return 8'("0" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] rand_name_char(bit first);
    int r;
    r = first ? $urandom_range(0, 51) : $urandom_range(0, 63);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return (r == 62) ? "_" : "-";
  endfunction

  task automatic put_length_header(string v);
    logic [7:0] ch;
    for (int j = 0; j < KEY_LEN; j++) begin
      ch = KEY_TEXT[8*(KEY_LEN-1-j) +: 8];
      if (ch != "-" && $urandom_range(0, 1)) ch = ch - 8'd32;
      put_byte(ch);
    end
    put_byte(":");
    repeat ($urandom_range(0, 2)) put_byte(SP);
    put_text(v);
    put_byte(CR);
    put_byte(LF);
  endtask

  task automatic put_plain_header();
    int r;
    r = $urandom_range(0, 99);
    // near misses of the length key must not be taken as one
    if (r < 5) put_text("Content-Lengthy");
    else if (r < 10) put_text("content-lengt");
    else begin
      put_byte(rand_name_char(1'b1));
      repeat ($urandom_range(0, 7)) put_byte(rand_name_char(1'b0));
    end
    put_byte(":");
    repeat ($urandom_range(0, 3)) put_byte(SP);
    repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(32, 125)));
    put_byte(CR);
    put_byte(LF);
  endtask

  task automatic queue_packet();
    int    start;
    int    nh;
    int    len_at;
    int    sel;
    int    n;
    int    lim;
    int    k;
    bit    broken;
    string val;
    start  = tx_q.size();
    broken = 1'b0;
    n      = 0;
    lim    = int'(ps_max_len);
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
      tx_q.push_back(mk_in(1'b1, 8'($urandom)));
      return;
    end
    put_byte(rand_upper());
    repeat ($urandom_range(0, 5)) put_byte(rand_ident());
    put_byte(SP);
    put_byte(rand_upper());
    repeat ($urandom_range(0, 5)) put_byte(rand_ident());
    put_byte(CR);
    put_byte(LF);
    nh = $urandom_range(0, 3);
    len_at = ($urandom_range(0, 99) < 65) ? $urandom_range(0, nh) : -1;
    for (int i = 0; i <= nh; i++) begin
      if (i == len_at) begin
        sel = $urandom_range(0, 19);
        case (sel)
          0: val = "0";
          1: val = "";
          2: val = $sformatf("%0da", $urandom_range(1, 9));
          3: val = "99999999";
          4: val = $sformatf("%0d", lim + 1);
          5: val = $sformatf("%0d ", $urandom_range(1, 9));
          6: begin
            n = (lim <= 40) ? lim : $urandom_range(1, 9);
            val = $sformatf("00%0d", n);
          end
          default: begin
            n = $urandom_range(1, (lim < 12) ? lim : 12);
            val = $sformatf("%0d", n);
          end
        endcase
        broken = sel <= 5;
        put_length_header(val);
        if ($urandom_range(0, 99) < 6) begin
          put_length_header("1");
          broken = 1'b1;
        end
      end
      if (i < nh) put_plain_header();
    end
    put_byte(CR);
    put_byte(LF);
    if (!broken) repeat (n) put_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 12) begin
      k = $urandom_range(start, tx_q.size() - 1);
      tx_q[k].data_byte = 8'($urandom_range(0, 255));
      broken = 1'b1;
    end
    if ($urandom_range(0, 99) < 5) begin
      k = $urandom_range(start + 1, tx_q.size() - 1);
      while (tx_q.size() > k) void'(tx_q.pop_back());
      broken = 1'b1;
    end
    if (broken || $urandom_range(0, 99) < 5) tx_q.push_back(mk_in(1'b1, 8'($urandom)));
  endtask

  // ----------------------------------------------------------------- main
  initial begin
    logic [15:0] cfg_plan [5];
    int          phase_start;
    bit          paused;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    row_typed   = 1'b0;
    row_want    = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    err_count   = 0;
    items_sent  = 0;
    burst_left  = 0;
    steady_send = 1'b0;
    hold_req    = 1'b0;
    ps_max_len  = tpp_pkg::MAX_LEN_RST;
    ps_halted   = 1'b0;
    start_packet();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: error codes, halting, restart, bodyless packet; limit at reset
    dir_tab.push_back(row(1'b1, 8'h00, 1, '0));
    dir_tab.push_back(row(1'b0, "a", 1,
      mk_result("a", tpp_pkg::KIND_PROTO, 0, 0, tpp_pkg::ERR_PROTO_START)));
    dir_tab.push_back(row(1'b0, 8'hFF, 1,
      mk_result(8'hFF, tpp_pkg::KIND_DELIM, 0, 0, tpp_pkg::ERR_HALTED)));
    dir_tab.push_back(row(1'b1, 8'hFF, 1, '0));
    dir_tab.push_back(row(1'b0, "A", 1,
      mk_result("A", tpp_pkg::KIND_PROTO, 1, 0, tpp_pkg::ERR_OK)));
    dir_tab.push_back(row(1'b0, "#", 1,
      mk_result("#", tpp_pkg::KIND_PROTO, 0, 0, tpp_pkg::ERR_PROTO_CHAR)));
    dir_tab.push_back(row(1'b1, 8'h00, 1, '0));
    dir_tab.push_back(row(1'b0, "Z", 0, '0));
    dir_tab.push_back(row(1'b0, SP, 0, '0));
    dir_tab.push_back(row(1'b0, "1", 1,
      mk_result("1", tpp_pkg::KIND_METHOD, 0, 0, tpp_pkg::ERR_METHOD_START)));
    dir_tab.push_back(row(1'b1, 8'h00, 1, '0));
    dir_tab.push_back(row(1'b0, "Z", 0, '0));
    dir_tab.push_back(row(1'b0, SP, 0, '0));
    dir_tab.push_back(row(1'b0, "M", 0, '0));
    dir_tab.push_back(row(1'b0, CR, 0, '0));
    dir_tab.push_back(row(1'b0, "x", 1,
      mk_result("x", tpp_pkg::KIND_DELIM, 0, 0, tpp_pkg::ERR_MISSING_LF)));
    dir_tab.push_back(row(1'b1, 8'h00, 1, '0));
    dir_tab.push_back(row(1'b0, "Z", 0, '0));
    dir_tab.push_back(row(1'b0, SP, 0, '0));
    dir_tab.push_back(row(1'b0, "M", 0, '0));
    dir_tab.push_back(row(1'b0, CR, 0, '0));
    dir_tab.push_back(row(1'b0, LF, 0, '0));
    dir_tab.push_back(row(1'b0, CR, 0, '0));
    dir_tab.push_back(row(1'b0, LF, 1,
      mk_result(LF, tpp_pkg::KIND_DELIM, 0, 1, tpp_pkg::ERR_OK)));
    dir_tab.push_back(row(1'b0, 8'h80, 1,
      mk_result(8'h80, tpp_pkg::KIND_PROTO, 0, 0, tpp_pkg::ERR_PROTO_START)));
    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    cfg_plan[0] = 16'd1;
    cfg_plan[1] = 16'($urandom_range(2, 30));
    cfg_plan[2] = 16'hFFFF;
    cfg_plan[3] = 16'($urandom_range(31, 65534));
    cfg_plan[4] = 16'd9;
    paused = 1'b0;
    for (int p = 0; p < 5; p++) begin
      wait_drained(6);
      set_max_len(cfg_plan[p]);
      // one phase runs back to back into a long receiver hold-off
      steady_send = p == 2;
      if (p == 2) hold_req = 1'b1;
      burst_left = 0;
      send_item(mk_in(1'b1, 8'($urandom)), 0, '0);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (p == 3 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
          wait_drained(0);
          paused = 1'b1;
        end
        queue_packet();
        while (tx_q.size() != 0) send_item(tx_q.pop_front(), 0, '0);
      end
    end

    wait_drained(8);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tpp_pkg.sv
rtl/tpp_in_reg.sv
rtl/tpp_step.sv
rtl/text_packet_header_parser_unit.sv
dv/text_packet_header_parser_unit_tb.sv
